// File: sv/utf8d_pkg.sv
// shared types, constants and lookup functions for the utf-8 character decoder
`default_nettype none

package utf8d_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned AvailW  = 3;
  localparam int unsigned ClassW  = 3;
  localparam int unsigned CountW  = 3;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned FullW   = 25;
  localparam int unsigned CpW     = 21;
  localparam int unsigned MinW    = 23;
  localparam int unsigned TailW   = 6;
  localparam int unsigned ErrW    = 9;

  // length classes
  localparam logic [ClassW-1:0] ClsBad   = 3'd0;
  localparam logic [ClassW-1:0] ClsOne   = 3'd1;
  localparam logic [ClassW-1:0] ClsTwo   = 3'd2;
  localparam logic [ClassW-1:0] ClsThree = 3'd3;
  localparam logic [ClassW-1:0] ClsFour  = 3'd4;

  // constants of the decode
  localparam logic [CodeW-1:0]  Replacement = 16'hFFFD;
  localparam logic [TailW-1:0]  TailExpect  = 6'h2A;
  localparam logic [9:0]        SurrogateHi = 10'h01B;
  localparam logic [MinW-1:0]   MaxBmp      = 23'h00FFFF;
  localparam logic [ByteW-1:0]  TailMask    = 8'h3F;
  localparam logic [CountW-1:0] MaxAvail    = 3'd4;

  // stage 1 result: limited window and lead class
  typedef struct packed {
    logic [ByteW-1:0]  b0;
    logic [ByteW-1:0]  b1;
    logic [ByteW-1:0]  b2;
    logic [ByteW-1:0]  b3;
    logic [ClassW-1:0] cls;
    logic [CountW-1:0] want;
  } s1_t;

  // stage 2 result: assembled value and tail marks
  typedef struct packed {
    logic [CpW-1:0]    cp;
    logic [TailW-1:0]  tail;
    logic [ClassW-1:0] cls;
    logic [CountW-1:0] want;
    logic [CountW-1:0] nz;
  } s2_t;

  // final result
  typedef struct packed {
    logic [CodeW-1:0]  code_point;
    logic [CountW-1:0] consumed;
    logic              invalid;
  } res_t;

  // length class from the top five bits of the lead byte
  function automatic logic [ClassW-1:0] class_of_lead(input logic [4:0] top);
    logic [ClassW-1:0] c;
    c = ClsBad;
    if (top[4] == 1'b0) begin
      c = ClsOne;
    end else if (top[4:2] == 3'b110) begin
      c = ClsTwo;
    end else if (top[4:1] == 4'b1110) begin
      c = ClsThree;
    end else if (top == 5'b11110) begin
      c = ClsFour;
    end
    return c;
  endfunction

  // bits of the lead byte that carry payload
  function automatic logic [ByteW-1:0] lead_mask(input logic [ClassW-1:0] cls);
    logic [ByteW-1:0] m;
    unique case (cls)
      ClsOne:   m = 8'h7F;
      ClsTwo:   m = 8'h1F;
      ClsThree: m = 8'h0F;
      ClsFour:  m = 8'h07;
      default:  m = 8'h00;
    endcase
    return m;
  endfunction

  // smallest canonical value of each class
  function automatic logic [MinW-1:0] min_value(input logic [ClassW-1:0] cls);
    logic [MinW-1:0] v;
    unique case (cls)
      ClsOne:   v = 23'h000000;
      ClsTwo:   v = 23'h000080;
      ClsThree: v = 23'h000800;
      ClsFour:  v = 23'h010000;
      default:  v = 23'h400000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: sv/utf8d_front.sv
// stage 1: lead class, window limit and masking of bytes past the limit
`default_nettype none

module utf8d_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              vld_i,
  output logic                             rdy_o,
  input  wire  [utf8d_pkg::ByteW-1:0]      byte_zero,
  input  wire  [utf8d_pkg::ByteW-1:0]      byte_one,
  input  wire  [utf8d_pkg::ByteW-1:0]      byte_two,
  input  wire  [utf8d_pkg::ByteW-1:0]      byte_three,
  input  wire  [utf8d_pkg::AvailW-1:0]     bytes_available,
  input  wire                              no_end_limit,
  output logic                             vld_o,
  input  wire                              rdy_i,
  output utf8d_pkg::s1_t                   dat_o
);

  logic                          vld_r;
  utf8d_pkg::s1_t                dat_r;
  utf8d_pkg::s1_t                dat_nxt;
  logic [utf8d_pkg::ClassW-1:0]  cls;
  logic [utf8d_pkg::CountW-1:0]  want;
  logic [utf8d_pkg::CountW-1:0]  limit;

  // class and wanted length
  always_comb begin
    cls  = utf8d_pkg::class_of_lead(byte_zero[7:3]);
    want = (cls == utf8d_pkg::ClsBad) ? utf8d_pkg::ClsOne : cls;
  end

  // window limit, availability saturates at four
  always_comb begin
    if (no_end_limit) begin
      limit = want;
    end else if (bytes_available > utf8d_pkg::MaxAvail) begin
      limit = utf8d_pkg::MaxAvail;
    end else begin
      limit = bytes_available;
    end
  end

  // zero the bytes at or past the limit
  always_comb begin
    dat_nxt.b0   = (limit > 3'd0) ? byte_zero  : '0;
    dat_nxt.b1   = (limit > 3'd1) ? byte_one   : '0;
    dat_nxt.b2   = (limit > 3'd2) ? byte_two   : '0;
    dat_nxt.b3   = (limit > 3'd3) ? byte_three : '0;
    dat_nxt.cls  = cls;
    dat_nxt.want = want;
  end

  assign rdy_o = !vld_r || rdy_i;

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

`default_nettype wire

// File: sv/utf8d_assemble.sv
// stage 2: code point assembly by mask and shift, nonzero byte count
`default_nettype none

module utf8d_assemble (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             vld_i,
  output logic            rdy_o,
  input  utf8d_pkg::s1_t  dat_i,
  output logic            vld_o,
  input  wire             rdy_i,
  output utf8d_pkg::s2_t  dat_o
);

  logic                          vld_r;
  utf8d_pkg::s2_t                dat_r;
  utf8d_pkg::s2_t                dat_nxt;
  logic [utf8d_pkg::FullW-1:0]   full;
  logic [utf8d_pkg::FullW-1:0]   aligned;
  logic [utf8d_pkg::ByteW-1:0]   lead;

  // place the payload bits of all four bytes
  always_comb begin
    lead = dat_i.b0 & utf8d_pkg::lead_mask(dat_i.cls);
    full = {lead[6:0], 18'd0}
         | {7'd0, dat_i.b1[5:0], 12'd0}
         | {13'd0, dat_i.b2[5:0], 6'd0}
         | {19'd0, dat_i.b3[5:0]};
  end

  // right-align by class
  always_comb begin
    unique case (dat_i.cls)
      utf8d_pkg::ClsOne:   aligned = full >> 18;
      utf8d_pkg::ClsTwo:   aligned = full >> 12;
      utf8d_pkg::ClsThree: aligned = full >> 6;
      default:             aligned = full;
    endcase
  end

  // next payload
  always_comb begin
    dat_nxt.cp   = aligned[utf8d_pkg::CpW-1:0];
    dat_nxt.tail = {dat_i.b1[7:6], dat_i.b2[7:6], dat_i.b3[7:6]};
    dat_nxt.cls  = dat_i.cls;
    dat_nxt.want = dat_i.want;
    dat_nxt.nz   = {2'd0, (dat_i.b0 != '0)} + {2'd0, (dat_i.b1 != '0)}
                 + {2'd0, (dat_i.b2 != '0)} + {2'd0, (dat_i.b3 != '0)};
  end

  assign rdy_o = !vld_r || rdy_i;

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

`default_nettype wire

// File: sv/utf8d_check.sv
// stage 3: error checks, replacement and consumed count, output register
`default_nettype none

module utf8d_check (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              vld_i,
  output logic             rdy_o,
  input  utf8d_pkg::s2_t   dat_i,
  output logic             vld_o,
  input  wire              rdy_i,
  output utf8d_pkg::res_t  dat_o
);

  logic                          vld_r;
  utf8d_pkg::res_t               dat_r;
  utf8d_pkg::res_t               dat_nxt;
  logic [utf8d_pkg::MinW-1:0]    cp_w;
  logic [utf8d_pkg::ErrW-1:0]    err;
  logic [utf8d_pkg::ErrW-1:0]    err_sh;
  logic                          bad;

  // error vector: range, surrogate, overlong and tail marks
  always_comb begin
    cp_w = {2'd0, dat_i.cp};
    err  = {(cp_w > utf8d_pkg::MaxBmp),
            (dat_i.cp[20:11] == utf8d_pkg::SurrogateHi),
            (cp_w < utf8d_pkg::min_value(dat_i.cls)),
            (dat_i.tail ^ utf8d_pkg::TailExpect)};
  end

  // drop the checks that do not apply to the class
  always_comb begin
    unique case (dat_i.cls)
      utf8d_pkg::ClsOne:   err_sh = err >> 6;
      utf8d_pkg::ClsTwo:   err_sh = err >> 4;
      utf8d_pkg::ClsThree: err_sh = err >> 2;
      default:             err_sh = err;
    endcase
    bad = (err_sh != '0);
  end

  // result
  always_comb begin
    dat_nxt.invalid    = bad;
    dat_nxt.code_point = bad ? utf8d_pkg::Replacement : dat_i.cp[utf8d_pkg::CodeW-1:0];
    dat_nxt.consumed   = (bad && (dat_i.nz < dat_i.want)) ? dat_i.nz : dat_i.want;
  end

  assign rdy_o = !vld_r || rdy_i;

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

`default_nettype wire

// File: sv/utf8_char_decoder_core.sv
// utf-8 character decoder, top level with stream ports
// path: an accepted request is registered in stage 1, stage 2 and stage 3 before its result is on the output
// throughput: one request per cycle while out_tready is high, set by the three-stage register pipeline
// each stage holds its item while the next one stalls; nothing is dropped
// reset: rst_n low clears the stage valid bits only, the payload registers are not reset
`default_nettype none

module utf8_char_decoder_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // byte_zero, byte_one, byte_two, byte_three, bytes_available, no_end_limit, zero pad
  input  wire  [39:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // code_point, consumed, zero pad
  output logic [23:0] out_tdata,
  // invalid
  output logic [0:0]  out_tuser
);

  logic            s1_vld;
  logic            s1_rdy;
  utf8d_pkg::s1_t  s1_dat;
  logic            s2_vld;
  logic            s2_rdy;
  utf8d_pkg::s2_t  s2_dat;
  utf8d_pkg::res_t res;

  // stage 1
  utf8d_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .vld_i           (in_tvalid),
    .rdy_o           (in_tready),
    .byte_zero       (in_tdata[7:0]),
    .byte_one        (in_tdata[15:8]),
    .byte_two        (in_tdata[23:16]),
    .byte_three      (in_tdata[31:24]),
    .bytes_available (in_tdata[34:32]),
    .no_end_limit    (in_tdata[35]),
    .vld_o           (s1_vld),
    .rdy_i           (s1_rdy),
    .dat_o           (s1_dat)
  );

  // stage 2
  utf8d_assemble u_assemble (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (s1_vld),
    .rdy_o (s1_rdy),
    .dat_i (s1_dat),
    .vld_o (s2_vld),
    .rdy_i (s2_rdy),
    .dat_o (s2_dat)
  );

  // stage 3
  utf8d_check u_check (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (s2_vld),
    .rdy_o (s2_rdy),
    .dat_i (s2_dat),
    .vld_o (out_tvalid),
    .rdy_i (out_tready),
    .dat_o (res)
  );

  // output packing
  assign out_tdata = {5'd0, res.consumed, res.code_point};
  assign out_tuser = res.invalid;

endmodule

`default_nettype wire
